// File: hdl/kbm_pkg.sv
// Package for the keyword blocklist matcher: keyword table, result codes,
// the hand-off type between scanner and verdict stage, and helper functions.
// No dependencies.
package kbm_pkg;

  localparam int KW_COUNT  = 8;
  localparam int SUFFIX_BYTES = 6;
  localparam int WIN_BYTES = 5;

  // Keywords in check order, right-aligned, upper case.
  localparam logic [47:0] KW_VALUE [KW_COUNT] = '{
    48'h000000000020,   // space
    48'h00000000002C,   // comma
    48'h00000000003B,   // semicolon
    48'h000044524F50,   // DROP
    48'h00414C544552,   // ALTER
    48'h000000534554,   // SET
    48'h53454C454354,   // SELECT
    48'h555044415445    // UPDATE
  };

  localparam int KW_LEN [KW_COUNT] = '{1, 1, 1, 4, 5, 3, 6, 6};

  // Result codes for failed_keyword.
  localparam logic [3:0] FAIL_NONE      = 4'd0;
  localparam logic [3:0] FAIL_SPACE     = 4'd1;
  localparam logic [3:0] FAIL_COMMA     = 4'd2;
  localparam logic [3:0] FAIL_SEMICOLON = 4'd3;
  localparam logic [3:0] FAIL_DROP      = 4'd4;
  localparam logic [3:0] FAIL_ALTER     = 4'd5;
  localparam logic [3:0] FAIL_SET       = 4'd6;
  localparam logic [3:0] FAIL_SELECT    = 4'd7;
  localparam logic [3:0] FAIL_UPDATE    = 4'd8;

  localparam logic [3:0] FAIL_CODE [KW_COUNT] = '{
    FAIL_SPACE, FAIL_COMMA, FAIL_SEMICOLON, FAIL_DROP,
    FAIL_ALTER, FAIL_SET, FAIL_SELECT, FAIL_UPDATE
  };

  // Flags of a finished text, passed from scanner to verdict stage.
  typedef struct packed {
    logic                valid;
    logic [KW_COUNT-1:0] seen;
  } kbm_flags_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  // One flag per keyword that ends at the newest byte of the suffix.
  function automatic logic [KW_COUNT-1:0] kw_match(input logic [47:0] suffix);
    logic [KW_COUNT-1:0] m;
    logic [47:0]         mask;
    m = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      mask = '0;
      for (int j = 0; j < SUFFIX_BYTES; j++) begin
        if (j < KW_LEN[k]) begin
          mask[j*8 +: 8] = 8'hFF;
        end
      end
      m[k] = ((suffix & mask) == KW_VALUE[k]);
    end
    return m;
  endfunction

  // First enabled keyword in check order, or FAIL_NONE.
  function automatic logic [3:0] first_hit(input logic [KW_COUNT-1:0] hit);
    logic [3:0] code;
    code = FAIL_NONE;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) begin
        code = FAIL_CODE[k];
      end
    end
    return code;
  endfunction

endpackage

// File: hdl/kbm_if.sv
// Stream interfaces of the keyword blocklist matcher: byte input channel
// and verdict output channel, each with valid/ready. No dependencies.
interface kbm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface kbm_verdict_if;
  logic       valid;
  logic       ready;
  logic       text_valid;
  logic [3:0] failed_keyword;

  modport source (output valid, output text_valid, output failed_keyword, input ready);
  modport sink   (input valid, input text_valid, input failed_keyword, output ready);
endinterface

// File: hdl/keyword_blocklist_matcher.sv
// Channel       | Dir | Payload                       | Transaction
// --------------+-----+-------------------------------+---------------------------
// text_in       | in  | char_byte[7:0], last_byte     | one byte of a text
// verdict_out   | out | text_valid, failed_keyword[3:0]| one verdict per text
// cfg_we/wdata  | in  | check_enable[7:0]             | register write, no wait
//
// One byte is accepted every cycle while no last byte is held. A byte is
// taken into the input register; the seen flags of a finished text then
// move into the hand-off register, and from there the verdict reaches the
// output register, where it is offered to the receiver. Reset
// (synchronous, active high) empties the pipeline, clears the window and flags,
// and sets every check enable. A stall on the output backs up stage by stage;
// bytes not marked last keep flowing through the scanner while verdicts wait,
// and a last byte is held only when both the hand-off and output registers are
// occupied.
//
// Depends on kbm_pkg, kbm_if, kbm_scan and kbm_verdict.
module keyword_blocklist_matcher
  import kbm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  kbm_text_if.sink            text_in,
  kbm_verdict_if.source       verdict_out,
  input  logic                cfg_we,
  input  logic [KW_COUNT-1:0] cfg_wdata
);

  // Check enables, one bit per keyword in check order. They act only when the
  // verdict is formed, so the flags themselves are always recorded in full.
  logic [KW_COUNT-1:0] check_enable;

  // Seen flags of a finished text travelling from the scanner to the verdict
  // stage, with the back-pressure running the other way.
  kbm_flags_t flags;
  logic       flags_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable <= '1;
    end else if (cfg_we) begin
      check_enable <= cfg_wdata;
    end
  end

  // The scanner upper-cases each byte, matches every keyword ending at it
  // against the window and records the hits. The window and flags clear once
  // a text ends, so no keyword spans two texts.
  kbm_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .text_in     (text_in),
    .flags       (flags),
    .flags_ready (flags_ready)
  );

  // The verdict stage reports the first enabled keyword that was seen.
  kbm_verdict u_verdict (
    .clk          (clk),
    .rst          (rst),
    .flags        (flags),
    .flags_ready  (flags_ready),
    .check_enable (check_enable),
    .verdict_out  (verdict_out)
  );

endmodule

// File: hdl/kbm_scan.sv
// Scanner: input register, five-byte window and seen flags; hands the flags
// of each finished text to the verdict stage. Uses kbm_pkg and kbm_text_if.
module kbm_scan
  import kbm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  kbm_text_if.sink     text_in,
  output kbm_flags_t   flags,
  input  logic         flags_ready
);

  logic                      in_vld;
  logic [7:0]                in_char;
  logic                      in_last;
  logic [WIN_BYTES*8-1:0]    window;
  logic [KW_COUNT-1:0]       seen;
  logic [47:0]               suffix;
  logic [KW_COUNT-1:0]       seen_next;
  logic                      flags_free;
  logic                      advance;

  assign suffix     = {window, upcase(in_char)};
  assign seen_next  = seen | kw_match(suffix);
  assign flags_free = !flags.valid || flags_ready;
  // A last byte may only move on when the hand-off register has room.
  assign advance    = in_vld && (!in_last || flags_free);
  assign text_in.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld      <= 1'b0;
      window      <= '0;
      seen        <= '0;
      flags.valid <= 1'b0;
    end else begin
      if (text_in.ready) begin
        in_vld <= text_in.valid;
      end
      if (advance) begin
        if (in_last) begin
          window <= '0;
          seen   <= '0;
        end else begin
          window <= suffix[WIN_BYTES*8-1:0];
          seen   <= seen_next;
        end
      end
      if (flags_free) begin
        flags.valid <= advance && in_last;
        flags.seen  <= seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.ready && text_in.valid) begin
      in_char <= text_in.char_byte;
      in_last <= text_in.last_byte;
    end
  end

endmodule

// File: hdl/kbm_verdict.sv
// Verdict stage: masks the seen flags with the enables, picks the first
// keyword in check order and holds the result in the output register.
// Uses kbm_pkg and kbm_verdict_if.
module kbm_verdict
  import kbm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  kbm_flags_t          flags,
  output logic                flags_ready,
  input  logic [KW_COUNT-1:0] check_enable,
  kbm_verdict_if.source       verdict_out
);

  logic [3:0] code;

  assign code        = first_hit(flags.seen & check_enable);
  assign flags_ready = !verdict_out.valid || verdict_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_out.valid <= 1'b0;
    end else if (flags_ready) begin
      verdict_out.valid <= flags.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (flags_ready) begin
      verdict_out.failed_keyword <= code;
      verdict_out.text_valid     <= (code == FAIL_NONE);
    end
  end

endmodule

// File: sim/kbm_verdict_checker.sv
// Checker for the keyword blocklist matcher. It watches the text and verdict channels
// and the register port, predicts each verdict and compares it with what arrives.
// Depends on kbm_pkg and kbm_if.
module kbm_verdict_checker
  import kbm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  kbm_text_if                 text_mon,
  kbm_verdict_if              verdict_mon,
  input  logic                cfg_we,
  input  logic [KW_COUNT-1:0] cfg_wdata,
  output int                  fail_count,
  output int                  verdicts_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       text_valid;
    logic [3:0] failed_keyword;
  } verdict_t;

  localparam logic [3:0] REASON [KW_COUNT] = '{
    FAIL_SPACE, FAIL_COMMA, FAIL_SEMICOLON, FAIL_DROP,
    FAIL_ALTER, FAIL_SET, FAIL_SELECT, FAIL_UPDATE
  };

  logic [39:0]         window;
  logic [KW_COUNT-1:0] seen;
  logic [KW_COUNT-1:0] enables;
  verdict_t            due [$];
  int                  errors;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'h20 : c;
  endfunction

  // Keywords whose last letter is the newest byte of the six-byte tail.
  function automatic logic [KW_COUNT-1:0] words_ending(input logic [47:0] tail);
    logic [KW_COUNT-1:0] hit;
    hit[0] = (tail[7:0] == " ");
    hit[1] = (tail[7:0] == ",");
    hit[2] = (tail[7:0] == ";");
    hit[3] = (tail[31:0] == "DROP");
    hit[4] = (tail[39:0] == "ALTER");
    hit[5] = (tail[23:0] == "SET");
    hit[6] = (tail == "SELECT");
    hit[7] = (tail == "UPDATE");
    return hit;
  endfunction

  function automatic verdict_t judge(input logic [KW_COUNT-1:0] hits);
    verdict_t v;
    v.failed_keyword = FAIL_NONE;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (hits[k] && v.failed_keyword == FAIL_NONE) begin
        v.failed_keyword = REASON[k];
      end
    end
    v.text_valid = (v.failed_keyword == FAIL_NONE);
    return v;
  endfunction

  always @(posedge clk) begin : monitor
    logic [47:0]         tail;
    logic [KW_COUNT-1:0] seen_now;
    verdict_t            want;
    if (rst) begin
      window  <= '0;
      seen    <= '0;
      enables <= '1;
      due.delete();
    end else begin
      if (cfg_we) begin
        enables <= cfg_wdata;
      end
      // Verdicts are retired before new texts are queued, so a verdict can
      // never be matched against a text that finished in the same cycle.
      if (verdict_mon.valid && verdict_mon.ready) begin
        if (due.size() == 0) begin
          errors++;
          $display("%0t: verdict with no text waiting: text_valid %0b failed_keyword %0d",
                   $time, verdict_mon.text_valid, verdict_mon.failed_keyword);
        end else begin
          want = due.pop_front();
          if (verdict_mon.text_valid !== want.text_valid) begin
            errors++;
            $display("%0t: text_valid expected %0b, got %0b",
                     $time, want.text_valid, verdict_mon.text_valid);
          end
          if (verdict_mon.failed_keyword !== want.failed_keyword) begin
            errors++;
            $display("%0t: failed_keyword expected %0d, got %0d",
                     $time, want.failed_keyword, verdict_mon.failed_keyword);
          end
        end
      end
      if (text_mon.valid && text_mon.ready) begin
        tail     = {window, fold_case(text_mon.char_byte)};
        seen_now = seen | words_ending(tail);
        if (text_mon.last_byte) begin
          due.push_back(judge(seen_now & enables));
          window <= '0;
          seen   <= '0;
        end else begin
          window <= tail[39:0];
          seen   <= seen_now;
        end
      end
    end
    verdicts_due <= due.size();
    fail_count   <= errors;
  end

endmodule

// File: sim/keyword_blocklist_matcher_test.sv
// Top level of the keyword blocklist matcher testbench: clock, reset, text stimulus,
// verdict back-pressure, register writes and the final verdict.
// Depends on kbm_pkg, kbm_if, keyword_blocklist_matcher and kbm_verdict_checker.
module keyword_blocklist_matcher_test;
  import kbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [KW_COUNT-1:0] cfg_wdata;
  int                  fail_count;
  int                  verdicts_due;

  // When set, the sender and the receiver both run without gaps, so that
  // back-to-back transactions are seen as well as scattered ones.
  bit                  steady;
  int unsigned         bytes_sent;

  string keyword_text [KW_COUNT] = '{" ", ",", ";", "DROP", "ALTER", "SET", "SELECT", "UPDATE"};
  string letters = "ACDELOPRSTU";

  kbm_text_if    text_ch ();
  kbm_verdict_if verdict_ch ();

  keyword_blocklist_matcher u_top (
    .clk         (clk),
    .rst         (rst),
    .text_in     (text_ch),
    .verdict_out (verdict_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  kbm_verdict_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .text_mon     (text_ch),
    .verdict_mon  (verdict_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .verdicts_due (verdicts_due)
  );

  always #5ns clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Upper-case letters come out in lower case half of the time, since the
  // block is meant to fold case before matching.
  function automatic logic [7:0] mixed_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  // One byte transaction. Valid is only lowered when a gap is wanted, so a
  // byte that follows straight on keeps valid high without a second update.
  task automatic send_byte(input logic [7:0] c, input logic fin);
    int unsigned gap;
    gap = steady ? 0 : pause_len();
    if (gap != 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.char_byte <= c;
    text_ch.last_byte <= fin;
    do @(posedge clk); while (!text_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  // A random text. Most are built from whole keywords, broken keywords
  // (one letter missing), letters that keywords are made of and random
  // bytes; some use letters alone so that clean texts come up often too.
  task automatic send_random_text();
    logic [7:0]  chars [$];
    int unsigned len;
    int unsigned pick;
    int unsigned skip;
    bit          clean;
    string       word;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    clean = ($urandom_range(0, 9) < 3);
    while (chars.size() < len) begin
      pick = clean ? 60 : $urandom_range(0, 99);
      if (pick < 35) begin
        word = keyword_text[$urandom_range(0, KW_COUNT - 1)];
        for (int k = 0; k < word.len(); k++) chars.push_back(mixed_case(word[k]));
      end else if (pick < 50) begin
        word = keyword_text[$urandom_range(3, KW_COUNT - 1)];
        skip = $urandom_range(0, word.len() - 1);
        for (int k = 0; k < word.len(); k++) begin
          if (k != skip) chars.push_back(mixed_case(word[k]));
        end
      end else if (pick < 80) begin
        chars.push_back(mixed_case(letters[$urandom_range(0, letters.len() - 1)]));
      end else begin
        chars.push_back(8'($urandom_range(0, 255)));
      end
    end
    steady = ($urandom_range(0, 7) == 0);
    foreach (chars[i]) send_byte(chars[i], i == chars.size() - 1);
  endtask

  // The register may only change with no text in flight: wait for every
  // verdict, then let the pipeline drain. The count of outstanding verdicts
  // is registered, so it is first read after the next clock edge.
  task automatic settle();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_enables(input logic [KW_COUNT-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // The receiver alternates between runs of ready and stalls of random
  // length; in steady stretches it simply stays ready.
  initial begin : receiver
    verdict_ch.ready <= 1'b0;
    forever begin
      verdict_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if (!steady) begin
        verdict_ch.ready <= 1'b0;
        repeat (pause_len() + 1) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [KW_COUNT-1:0] setting [8];
    int unsigned         phase_start;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    text_ch.valid     <= 1'b0;
    text_ch.char_byte <= '0;
    text_ch.last_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed texts with every check enabled, as after reset: the byte
    // extremes, each keyword on its own in varied case, and the bytes just
    // outside the lower-case range, which must not be folded.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text(" ");
    send_text(",");
    send_text(";");
    send_text("dRoP");
    send_text("alter");
    send_text("SeT");
    send_text("select");
    send_text("UpDate");
    send_text("`{az");

    // Random phases, each under its own enable mask: none, all, single
    // checks at either end of the order, alternating patterns and random.
    setting = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h00, 8'h00};
    setting[6] = KW_COUNT'($urandom_range(0, 255));
    setting[7] = KW_COUNT'($urandom_range(0, 255));
    foreach (setting[p]) begin
      settle();
      write_enables(setting[p]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 150) send_random_text();
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && verdicts_due == 0) begin
      $display("keyword_blocklist_matcher regression: pass");
    end else begin
      $display("keyword_blocklist_matcher regression: fail");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin : watchdog
    #5ms;
    $display("keyword_blocklist_matcher regression: fail");
    $finish;
  end

endmodule
